// File: rtl/core/bses_pkg.sv
`default_nettype none
package bses_pkg;

  localparam int unsigned NumObjectsDef = 16;
  localparam int unsigned WaitDepthDef  = 32;
  localparam int unsigned NodeBitsDef   = 8;
  localparam int unsigned ThreadBitsDef = 16;

  localparam int unsigned ModeW = 3;
  localparam int unsigned KindW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_BAR_ENTER = 3'd0,
    MODE_SEM_ENTER = 3'd1,
    MODE_SEM_LEAVE = 3'd2,
    MODE_EV_WAIT   = 3'd3,
    MODE_EV_SET    = 3'd4,
    MODE_EV_RESET  = 3'd5
  } mode_e;

  typedef enum logic [KindW-1:0] {
    RES_WAKE       = 2'd0,
    RES_TABLE_FULL = 2'd1,
    RES_QUEUE_FULL = 2'd2
  } res_kind_e;

endpackage
`default_nettype wire

// File: rtl/core/barrier_semaphore_event_sync_engine_top.sv
`default_nettype none
// Synchronization engine for barriers, semaphores and events.
// A request word on the input channel names an operation, an object key and
// the requesting node and thread; it is taken when in_valid_i is high and
// in_stall_o is low. The result channel carries wake words and error words;
// the final word of a request has last_o set. A request may give no word.
// A request passes through key lookup, priority encode with entry read and
// update before its first result. A table full word comes after the lookup
// and priority encode, and a semaphore leave that only wakes a waiter gives
// its word after the update, the waiter memory read and the output register.
// A stalled result word holds back the words after it. Each queued waiter
// that is woken passes through the waiter memory read and the single output
// register. The engine handles one request at a time and stalls the input
// until the request is finished.
// Reset empties the object table at once; no clearing pass is needed. The
// input is stalled while reset is asserted.
// While the receiver stalls, the result word is held and no progress is
// made until it is taken.
module barrier_semaphore_event_sync_engine_top
  import bses_pkg::*;
#(
  parameter int unsigned NUM_OBJECTS = bses_pkg::NumObjectsDef,
  parameter int unsigned WAIT_DEPTH  = bses_pkg::WaitDepthDef,
  parameter int unsigned NODE_BITS   = bses_pkg::NodeBitsDef,
  parameter int unsigned THREAD_BITS = bses_pkg::ThreadBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [31:0] object_key_i,
  input  wire logic [7:0]  src_node_i,
  input  wire logic [15:0] thread_id_i,
  input  wire logic [31:0] init_count_i,
  input  wire logic        init_signaled_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  result_kind_o,
  output logic      [7:0]  wake_node_o,
  output logic      [15:0] wake_thread_o,
  output logic             last_o
);

  localparam int unsigned EB = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int unsigned HB = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned CB = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned SW = CB + 1;
  localparam int unsigned EW = 64 + HB + CB;
  localparam int unsigned WW = NODE_BITS + THREAD_BITS;
  localparam int unsigned WDEPTH = NUM_OBJECTS << HB;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ENC, ST_EXEC, ST_PRD, ST_PWT, ST_OUTW
  } state_e;

  state_e                 state_q;
  logic [2:0]             mode_q;
  logic [31:0]            key_q;
  logic [NODE_BITS-1:0]   node_q;
  logic [THREAD_BITS-1:0] thr_q;
  logic [31:0]            init_q;
  logic                   sig_q;
  logic [EB-1:0]          e_q;
  logic                   alloc_q;
  logic [HB-1:0]          pp_q;
  logic [CB-1:0]          rem_q;
  logic                   out_valid_q;
  logic [1:0]             out_kind_q;
  logic [7:0]             out_node_q;
  logic [15:0]            out_thr_q;
  logic                   out_last_q;

  logic          accept;
  logic          hit, free;
  logic [EB-1:0] hit_idx, free_idx;
  logic [EB-1:0] ent_raddr;
  logic [EW-1:0] ent_rdata, ent_wdata;
  logic          ent_we;
  logic [WW-1:0] wt_rdata, wt_wdata;
  logic          wt_we;
  logic [31:0]   node_in32, thr_in32, node_q32, thr_q32, wnode32, wthr32;

  logic [31:0]   c, l, nc, v_inc, v_dec;
  logic [HB-1:0] h, nh, slot, h_next;
  logic [CB-1:0] q, nq, pops;
  logic [SW-1:0] sum, hp, hq;
  logic          do_push, emit_req, emit_err, q_full;

  assign in_stall_o = !rst_ni || (state_q != ST_IDLE);
  assign accept    = in_valid_i && !in_stall_o;
  assign node_in32 = 32'(src_node_i);
  assign thr_in32  = 32'(thread_id_i);
  assign node_q32  = 32'(node_q);
  assign thr_q32   = 32'(thr_q);
  assign wnode32   = 32'(wt_rdata[WW-1:THREAD_BITS]);
  assign wthr32    = 32'(wt_rdata[THREAD_BITS-1:0]);
  assign ent_raddr = hit ? hit_idx : free_idx;

  bses_cam #(.NUM_OBJECTS(NUM_OBJECTS)) u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lookup_i   (accept),
    .key_i      (object_key_i),
    .alloc_i    (ent_we && alloc_q),
    .alloc_idx_i(e_q),
    .alloc_key_i(key_q),
    .hit_o      (hit),
    .hit_idx_o  (hit_idx),
    .free_o     (free),
    .free_idx_o (free_idx)
  );

  bses_ram #(.WIDTH(EW), .DEPTH(NUM_OBJECTS)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(e_q),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  bses_ram #(.WIDTH(WW), .DEPTH(WDEPTH)) u_waiter_ram (
    .clk_i  (clk_i),
    .we_i   (wt_we),
    .waddr_i({e_q, slot}),
    .wdata_i(wt_wdata),
    .raddr_i({e_q, pp_q}),
    .rdata_o(wt_rdata)
  );

  always_comb begin
    if (alloc_q) begin
      h = '0;
      q = '0;
      unique case (mode_q)
        MODE_BAR_ENTER: begin
          l = init_q;
          c = '0;
        end
        MODE_SEM_ENTER, MODE_SEM_LEAVE: begin
          l = init_q;
          c = init_q;
        end
        default: begin
          l = {31'b0, (init_q != 32'd0)};
          c = {31'b0, sig_q};
        end
      endcase
    end else begin
      c = ent_rdata[EW-1 -: 32];
      l = ent_rdata[EW-33 -: 32];
      h = ent_rdata[CB +: HB];
      q = ent_rdata[CB-1:0];
    end

    v_inc  = c + 32'd1;
    v_dec  = c - 32'd1;
    q_full = (q == CB'(WAIT_DEPTH));
    sum    = SW'(h) + SW'(q);
    slot   = (sum >= SW'(WAIT_DEPTH)) ? HB'(sum - SW'(WAIT_DEPTH)) : HB'(sum);
    hp     = SW'(h) + SW'(1);
    h_next = (hp == SW'(WAIT_DEPTH)) ? '0 : HB'(hp);
    hq     = sum;

    nc       = c;
    nh       = h;
    nq       = q;
    pops     = '0;
    do_push  = 1'b0;
    emit_req = 1'b0;
    emit_err = 1'b0;

    unique case (mode_q)
      MODE_BAR_ENTER: begin
        if ($signed(v_inc) >= $signed(l)) begin
          nc = '0; nh = '0; nq = '0;
          emit_req = 1'b1;
          pops = q;
        end else if (q_full) begin
          emit_err = 1'b1;
        end else begin
          nc = v_inc; do_push = 1'b1; nq = q + CB'(1);
        end
      end
      MODE_SEM_ENTER: begin
        if (!v_dec[31]) begin
          nc = v_dec; emit_req = 1'b1;
        end else if (q_full) begin
          emit_err = 1'b1;
        end else begin
          nc = v_dec; do_push = 1'b1; nq = q + CB'(1);
        end
      end
      MODE_SEM_LEAVE: begin
        nc = v_inc;
        if (!v_inc[31] && (q != '0)) begin
          pops = CB'(1); nh = h_next; nq = q - CB'(1);
        end
      end
      MODE_EV_WAIT: begin
        if (c != 32'd0) begin
          emit_req = 1'b1;
          if (l != 32'd0) begin
            nc = '0;
          end
        end else if (q_full) begin
          emit_err = 1'b1;
        end else begin
          do_push = 1'b1; nq = q + CB'(1);
        end
      end
      MODE_EV_SET: begin
        nc = 32'd1;
        if (l != 32'd0) begin
          if (q != '0) begin
            nc = '0; pops = CB'(1); nh = h_next; nq = q - CB'(1);
          end
        end else begin
          pops = q;
          nq   = '0;
          nh   = (hq >= SW'(WAIT_DEPTH)) ? HB'(hq - SW'(WAIT_DEPTH)) : HB'(hq);
        end
      end
      default: begin
        nc = '0;
      end
    endcase

    ent_we    = (state_q == ST_EXEC);
    ent_wdata = {nc, l, nh, nq};
    wt_we     = (state_q == ST_EXEC) && do_push;
    wt_wdata  = {node_q, thr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      alloc_q     <= 1'b0;
      rem_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_ENC;
          end
        end
        ST_ENC: begin
          if (mode_q > MODE_EV_RESET) begin
            state_q <= ST_IDLE;
          end else if (hit) begin
            e_q     <= hit_idx;
            alloc_q <= 1'b0;
            state_q <= ST_EXEC;
          end else if (free) begin
            e_q     <= free_idx;
            alloc_q <= 1'b1;
            state_q <= ST_EXEC;
          end else begin
            out_valid_q <= 1'b1;
            out_kind_q  <= RES_TABLE_FULL;
            out_node_q  <= node_q32[7:0];
            out_thr_q   <= thr_q32[15:0];
            out_last_q  <= 1'b1;
            rem_q       <= '0;
            state_q     <= ST_OUTW;
          end
        end
        ST_EXEC: begin
          rem_q <= pops;
          pp_q  <= h;
          if (emit_req || emit_err) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= emit_err ? RES_QUEUE_FULL : RES_WAKE;
            out_node_q  <= node_q32[7:0];
            out_thr_q   <= thr_q32[15:0];
            out_last_q  <= (pops == '0);
            state_q     <= ST_OUTW;
          end else if (pops != '0) begin
            state_q <= ST_PRD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_PRD: begin
          state_q <= ST_PWT;
        end
        ST_PWT: begin
          out_valid_q <= 1'b1;
          out_kind_q  <= RES_WAKE;
          out_node_q  <= wnode32[7:0];
          out_thr_q   <= wthr32[15:0];
          out_last_q  <= (rem_q == CB'(1));
          rem_q       <= rem_q - CB'(1);
          pp_q        <= ((SW'(pp_q) + SW'(1)) == SW'(WAIT_DEPTH)) ? '0 : pp_q + HB'(1);
          state_q     <= ST_OUTW;
        end
        ST_OUTW: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= (rem_q != '0) ? ST_PRD : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= object_key_i;
      node_q <= node_in32[NODE_BITS-1:0];
      thr_q  <= thr_in32[THREAD_BITS-1:0];
      init_q <= init_count_i;
      sig_q  <= init_signaled_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign wake_node_o   = out_node_q;
  assign wake_thread_o = out_thr_q;
  assign last_o        = out_last_q;

endmodule
`default_nettype wire

// File: rtl/core/bses_ram.sv
`default_nettype none
module bses_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/bses_cam.sv
`default_nettype none
module bses_cam #(
  parameter int unsigned NUM_OBJECTS = 16,
  localparam int unsigned EB = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          lookup_i,
  input  wire logic [31:0]   key_i,
  input  wire logic          alloc_i,
  input  wire logic [EB-1:0] alloc_idx_i,
  input  wire logic [31:0]   alloc_key_i,
  output logic               hit_o,
  output logic      [EB-1:0] hit_idx_o,
  output logic               free_o,
  output logic      [EB-1:0] free_idx_o
);

  logic [NUM_OBJECTS-1:0] valid_q;
  logic [NUM_OBJECTS-1:0] hit_q;
  logic [31:0]            key_q [NUM_OBJECTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= '0;
    end else begin
      if (lookup_i) begin
        for (int i = 0; i < NUM_OBJECTS; i++) begin
          hit_q[i] <= valid_q[i] && (key_q[i] == key_i);
        end
      end
      if (alloc_i) begin
        valid_q[alloc_idx_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      key_q[alloc_idx_i] <= alloc_key_i;
    end
  end

  always_comb begin
    hit_o      = 1'b0;
    hit_idx_o  = '0;
    free_o     = 1'b0;
    free_idx_o = '0;
    for (int i = NUM_OBJECTS - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_o     = 1'b1;
        hit_idx_o = EB'(i);
      end
      if (!valid_q[i]) begin
        free_o     = 1'b1;
        free_idx_o = EB'(i);
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
  import bses_pkg::*;

  localparam int unsigned NObj = 16;
  localparam int unsigned WDep = 32;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  node;
    logic [15:0] thread;
    logic        last;
  } wake_word_t;

  class sync_scoreboard;
    bit          ent_used[NObj];
    logic [31:0] ent_key[NObj];
    logic [31:0] ent_cnt[NObj];
    logic [31:0] ent_lim[NObj];
    logic [23:0] waiters[NObj][WDep];
    int unsigned q_head[NObj];
    int unsigned q_cnt[NObj];
    wake_word_t  pending[$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < NObj; i++) ent_used[i] = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void add(logic [1:0] k, logic [7:0] nd, logic [15:0] th);
      wake_word_t w;
      w.kind = k;
      w.node = nd;
      w.thread = th;
      w.last = 0;
      pending = {pending, w};
    endfunction

    function void pop_one(int e);
      logic [23:0] w;
      w = waiters[e][q_head[e]];
      q_head[e] = (q_head[e] + 1) % WDep;
      q_cnt[e]--;
      add(RES_WAKE, w[23:16], w[15:0]);
    endfunction

    function void push_one(int e, logic [7:0] nd, logic [15:0] th);
      waiters[e][(q_head[e] + q_cnt[e]) % WDep] = {nd, th};
      q_cnt[e]++;
    endfunction

    function void note_request(logic [2:0] md, logic [31:0] key, logic [7:0] nd,
                               logic [15:0] th, logic [31:0] init, logic sig);
      int e;
      int n;
      int base;
      logic [31:0] v;
      e = -1;
      base = pending.size();
      if (md > MODE_EV_RESET) return;
      for (int i = 0; i < NObj; i++)
        if (e < 0 && ent_used[i] && ent_key[i] == key) e = i;
      if (e < 0) begin
        for (int i = 0; i < NObj; i++)
          if (e < 0 && !ent_used[i]) e = i;
        if (e < 0) begin
          add(RES_TABLE_FULL, nd, th);
          pending[$].last = 1;
          return;
        end
        ent_used[e] = 1;
        ent_key[e] = key;
        q_head[e] = 0;
        q_cnt[e] = 0;
        if (md == MODE_BAR_ENTER) begin
          ent_lim[e] = init;
          ent_cnt[e] = 0;
        end else if (md <= MODE_SEM_LEAVE) begin
          ent_lim[e] = init;
          ent_cnt[e] = init;
        end else begin
          ent_lim[e] = (init != 0) ? 32'd1 : 32'd0;
          ent_cnt[e] = {31'd0, sig};
        end
      end
      case (md)
        MODE_BAR_ENTER: begin
          v = ent_cnt[e] + 1;
          if ($signed(v) >= $signed(ent_lim[e])) begin
            ent_cnt[e] = 0;
            add(RES_WAKE, nd, th);
            while (q_cnt[e] > 0) pop_one(e);
            q_head[e] = 0;
          end else if (q_cnt[e] >= WDep) begin
            add(RES_QUEUE_FULL, nd, th);
          end else begin
            ent_cnt[e] = v;
            push_one(e, nd, th);
          end
        end
        MODE_SEM_ENTER: begin
          v = ent_cnt[e] - 1;
          if (!v[31]) begin
            ent_cnt[e] = v;
            add(RES_WAKE, nd, th);
          end else if (q_cnt[e] >= WDep) begin
            add(RES_QUEUE_FULL, nd, th);
          end else begin
            ent_cnt[e] = v;
            push_one(e, nd, th);
          end
        end
        MODE_SEM_LEAVE: begin
          ent_cnt[e] = ent_cnt[e] + 1;
          if (!ent_cnt[e][31] && q_cnt[e] > 0) pop_one(e);
        end
        MODE_EV_WAIT: begin
          if (ent_cnt[e] != 0) begin
            add(RES_WAKE, nd, th);
            if (ent_lim[e] != 0) ent_cnt[e] = 0;
          end else if (q_cnt[e] >= WDep) begin
            add(RES_QUEUE_FULL, nd, th);
          end else begin
            push_one(e, nd, th);
          end
        end
        MODE_EV_SET: begin
          ent_cnt[e] = 1;
          if (ent_lim[e] != 0) begin
            if (q_cnt[e] > 0) begin
              ent_cnt[e] = 0;
              pop_one(e);
            end
          end else begin
            while (q_cnt[e] > 0) pop_one(e);
          end
        end
        default: ent_cnt[e] = 0;
      endcase
      n = pending.size();
      if (n > base) pending[n-1].last = 1;
    endfunction

    function void check_word(wake_word_t got);
      wake_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected result word kind=%0d node=%0d thread=%0d",
               got.kind, got.node, got.thread);
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (got.kind !== w.kind) begin
        $error("result_kind expected %0d actual %0d", w.kind, got.kind); errors++;
      end
      if (got.node !== w.node) begin
        $error("wake_node expected %0d actual %0d", w.node, got.node); errors++;
      end
      if (got.thread !== w.thread) begin
        $error("wake_thread expected %0d actual %0d", w.thread, got.thread); errors++;
      end
      if (got.last !== w.last) begin
        $error("last expected %0d actual %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [31:0] object_key_i = '0;
  logic [7:0]  src_node_i = '0;
  logic [15:0] thread_id_i = '0;
  logic [31:0] init_count_i = '0;
  logic        init_signaled_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 1;
  logic [1:0]  result_kind_o;
  logic [7:0]  wake_node_o;
  logic [15:0] wake_thread_o;
  logic        last_o;

  barrier_semaphore_event_sync_engine_top dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  sync_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_rx = 0;
  bit  stim_done = 0;
  int  sent = 0;
  logic [31:0] keys[8];

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word('{result_kind_o, wake_node_o, wake_thread_o, last_o});
  end

  initial begin
    int gap;
    @(negedge clk_i);
    while (1) begin
      if (hold_rx) begin
        out_stall_i <= 1;
        @(negedge clk_i);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_stall_i <= (gap != 0);
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 0;
        @(negedge clk_i);
      end
    end
  end

  task automatic send_req(logic [2:0] md, logic [31:0] key, logic [7:0] nd,
                          logic [15:0] th, logic [31:0] init, logic sig, int gap);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= md;
    object_key_i <= key;
    src_node_i <= nd;
    thread_id_i <= th;
    init_count_i <= init;
    init_signaled_i <= sig;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(md, key, nd, th, init, sig);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] small_init();
    case ($urandom_range(0, 5))
      0: small_init = 32'h7fffffff;
      1: small_init = 32'h80000000;
      2: small_init = 32'hffffffff;
      default: small_init = $urandom_range(0, 4);
    endcase
  endfunction

  task automatic rand_req(bit noisy);
    logic [2:0] md;
    logic [31:0] key;
    int gp;
    md = noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
    key = (noisy && $urandom_range(0, 3) == 0) ? $urandom() : keys[$urandom_range(0, 7)];
    gp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    send_req(md, key, 8'($urandom()), 16'($urandom()), small_init(),
             1'($urandom_range(0, 1)), gp);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_req(MODE_BAR_ENTER, 32'h0, 8'h00, 16'h0000, 32'd3, 0, 0);
    send_req(MODE_BAR_ENTER, 32'h0, 8'hff, 16'hffff, 32'd3, 1, 0);
    send_req(MODE_BAR_ENTER, 32'h0, 8'h12, 16'h3456, 32'd3, 0, 0);
    send_req(MODE_SEM_ENTER, 32'hffffffff, 8'h01, 16'h0001, 32'd1, 0, 0);
    send_req(MODE_SEM_ENTER, 32'hffffffff, 8'h02, 16'h0002, 32'd1, 0, 0);
    send_req(MODE_SEM_LEAVE, 32'hffffffff, 8'h03, 16'h0003, 32'd1, 0, 0);
    send_req(MODE_SEM_LEAVE, 32'h5, 8'h04, 16'h0004, 32'h80000000, 0, 0);
    send_req(MODE_EV_WAIT, 32'h6, 8'h05, 16'h0005, 32'd0, 0, 0);
    send_req(MODE_EV_SET, 32'h6, 8'h06, 16'h0006, 32'd0, 0, 0);
    send_req(MODE_EV_WAIT, 32'h7, 8'h07, 16'h0007, 32'h7fffffff, 1, 0);
    send_req(MODE_EV_WAIT, 32'h7, 8'h08, 16'h0008, 32'd0, 0, 0);
    send_req(MODE_EV_SET, 32'h7, 8'h09, 16'h0009, 32'd0, 0, 0);
    send_req(MODE_EV_RESET, 32'h6, 8'h0a, 16'h000a, 32'd0, 0, 0);
    send_req(MODE_EV_RESET, 32'h8, 8'h0b, 16'h000b, 32'hffffffff, 1, 0);
    send_req(3'd6, 32'h9, 8'h0c, 16'h000c, 32'd0, 0, 0);
    send_req(3'd7, 32'h9, 8'h0d, 16'h000d, 32'd0, 0, 0);
    send_req(MODE_SEM_ENTER, 32'h6, 8'h0e, 16'h000e, 32'd0, 0, 0);
    send_req(MODE_BAR_ENTER, 32'ha, 8'h0f, 16'h000f, 32'h80000000, 0, 0);
    wait_drained();
    // Fill one barrier queue past its depth, then send an event set on its key, which wakes one waiter.
    for (int i = 0; i < WDep + 2; i++)
      send_req(MODE_BAR_ENTER, 32'hb, 8'(i), 16'(i * 7), 32'd100, 0, 0);
    send_req(MODE_EV_SET, 32'hb, 8'h55, 16'h5555, 32'd0, 0, 0);
    wait_drained();
    send_req(MODE_BAR_ENTER, 32'hc, 8'h1, 16'h1, 32'd0, 0, 0);
    for (int i = 0; i < 8; i++) send_req(MODE_EV_WAIT, 32'h100 + i, 8'h1, 16'h1, 32'd0, 0, 0);
    wait_drained();
    for (int i = 0; i < 8; i++) keys[i] = (i < 4) ? 32'h0 + i * 5 : $urandom();
    hold_rx = 1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_rx = 0;
      end
      for (int i = 0; i < 30; i++) rand_req(0);
    join
    for (int i = 0; i < 470; i++) begin
      if (i == 200) wait_drained();
      rand_req($urandom_range(0, 9) == 0);
    end
    wait_drained();
    repeat (200) @(negedge clk_i);
    $display("Sent %0d requests on barrier, semaphore and event objects;", sent);
    $display("checked %0d result words including table and queue overflow.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/bses_pkg.sv
rtl/core/bses_ram.sv
rtl/core/bses_cam.sv
rtl/core/barrier_semaphore_event_sync_engine_top.sv
tb/testbench.sv
